// ===== rtl/thd_pkg.sv =====
package thd_pkg;

   localparam logic OP_BYTE  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_TOO_BIG = 2'd1;
   localparam logic [1:0] STATUS_DROPPED = 2'd2;

   localparam logic [23:0] MAX_BODY_LENGTH_RESET = 24'd1048576;

   typedef struct packed {
      logic       has_result;
      logic [7:0] out_byte;
      logic [7:0] message_type;
      logic       is_header;
      logic       last_of_message;
      logic [1:0] status;
   } result_type;

endpackage

// ===== rtl/thd_core.sv =====
module thd_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic                step_op,
   input  logic [7:0]          step_byte,
   input  logic [23:0]         max_body_length,
   output thd_pkg::result_type result
);

   localparam logic [2:0] POS_TYPE    = 3'd0;
   localparam logic [2:0] POS_LEN_HI  = 3'd1;
   localparam logic [2:0] POS_LEN_MID = 3'd2;
   localparam logic [2:0] POS_LEN_LO  = 3'd3;
   localparam logic [2:0] POS_BODY    = 3'd4;

   logic [2:0]  pos_ff, pos_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] len_ff, len_in;
   logic [23:0] remain_ff, remain_in;
   logic        error_ff, error_in;
   logic [23:0] full_len;
   logic [23:0] remain_dec;

   always_comb begin
      pos_in    = pos_ff;
      type_in   = type_ff;
      len_in    = len_ff;
      remain_in = remain_ff;
      error_in  = error_ff;
      full_len  = {len_ff, step_byte};
      remain_dec = (remain_ff != 24'd0) ? remain_ff - 24'd1 : 24'd0;

      result.has_result      = 1'b1;
      result.out_byte        = step_byte;
      result.message_type    = type_ff;
      result.is_header       = 1'b1;
      result.last_of_message = 1'b0;
      result.status          = thd_pkg::STATUS_OK;

      if (step_op == thd_pkg::OP_CLEAR) begin
         result.has_result = 1'b0;
         pos_in    = POS_TYPE;
         type_in   = 8'd0;
         len_in    = 16'd0;
         remain_in = 24'd0;
         error_in  = 1'b0;
      end else if (error_ff) begin
         result.out_byte     = 8'd0;
         result.message_type = 8'd0;
         result.is_header    = 1'b0;
         result.status       = thd_pkg::STATUS_DROPPED;
      end else begin
         case (pos_ff) inside
            POS_TYPE: begin
               type_in             = step_byte;
               len_in              = 16'd0;
               pos_in              = POS_LEN_HI;
               result.message_type = step_byte;
            end
            POS_LEN_HI, POS_LEN_MID: begin
               len_in = {len_ff[7:0], step_byte};
               pos_in = pos_ff + 3'd1;
            end
            POS_LEN_LO: begin
               len_in = full_len[15:0];
               if (full_len > max_body_length) begin
                  error_in      = 1'b1;
                  pos_in        = POS_TYPE;
                  result.status = thd_pkg::STATUS_TOO_BIG;
               end else if (full_len == 24'd0) begin
                  pos_in                 = POS_TYPE;
                  result.last_of_message = 1'b1;
               end else begin
                  remain_in = full_len;
                  pos_in    = POS_BODY;
               end
            end
            default: begin
               result.is_header = 1'b0;
               remain_in        = remain_dec;
               if (remain_dec == 24'd0) begin
                  pos_in                 = POS_TYPE;
                  result.last_of_message = 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= POS_TYPE;
         type_ff   <= 8'd0;
         len_ff    <= 16'd0;
         remain_ff <= 24'd0;
         error_ff  <= 1'b0;
      end else if (step) begin
         pos_ff    <= pos_in;
         type_ff   <= type_in;
         len_ff    <= len_in;
         remain_ff <= remain_in;
         error_ff  <= error_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      error_ff && !(step && step_op == thd_pkg::OP_CLEAR) |=> error_ff)
      else $error("length error dropped without clear");

   a_error_rest: assert property (@(posedge clock) disable iff (reset)
      error_ff |-> pos_ff == POS_TYPE)
      else $error("error latched mid-header");

   a_body_nonzero: assert property (@(posedge clock) disable iff (reset)
      pos_ff == POS_BODY |-> remain_ff != 24'd0)
      else $error("in body with nothing remaining");
`endif

endmodule

// ===== rtl/tls_handshake_deframer_unit.sv =====
// Splits a byte stream into TLS handshake messages (type byte, 24-bit big-endian
// body length, body) and passes every byte on as it arrives, tagged with its
// message type, a header mark, a last-of-message mark (tlast) and a status. A
// body length above csr_data's limit latches an error; later bytes come out as
// zeros with status "dropped" until a clear request, which also drops any
// partial message and produces no response. One request per cycle is taken
// while the response side is not stalled; a request passes through the input
// register, the combinational header and length logic and the response register.
module tls_handshake_deframer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [0:0]  req_tuser,   // [0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [15:8] message_type
   output logic [2:0]  rsp_tuser,   // [0] is_header, [2:1] status
   output logic        rsp_tlast,   // last_of_message
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_data     // max_body_length
);

   logic                in_valid_ff, in_valid_in;
   logic                in_op_ff, in_op_in;
   logic [7:0]          in_byte_ff, in_byte_in;
   logic [23:0]         max_len_ff;
   logic                out_valid_ff, out_valid_in;
   thd_pkg::result_type out_ff, out_in;
   thd_pkg::result_type result;
   logic                advance;

   thd_core u_core (
      .clock           (clock),
      .reset           (reset),
      .step            (advance),
      .step_op         (in_op_ff),
      .step_byte       (in_byte_ff),
      .max_body_length (max_len_ff),
      .result          (result)
   );

   assign advance    = in_valid_ff && (!result.has_result || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_op_in     = in_op_ff;
      in_byte_in   = in_byte_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_op_in    = req_tuser[0];
         in_byte_in  = req_tdata;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      if (advance && result.has_result) begin
         out_valid_in = 1'b1;
         out_in       = result;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         max_len_ff   <= thd_pkg::MAX_BODY_LENGTH_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            max_len_ff <= csr_data;
         end
      end
      in_op_ff   <= in_op_in;
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.message_type, out_ff.out_byte};
   assign rsp_tuser  = {out_ff.status, out_ff.is_header};
   assign rsp_tlast  = out_ff.last_of_message;

`ifndef NO_ASSERTIONS
   a_dropped_blank: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.status == thd_pkg::STATUS_DROPPED
      |-> rsp_tdata == 16'd0 && !rsp_tlast && !out_ff.is_header)
      else $error("dropped byte carries payload");

   a_too_big_header: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.status == thd_pkg::STATUS_TOO_BIG
      |-> out_ff.is_header && !rsp_tlast)
      else $error("length error not on a header byte");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_op_ff))
      else $error("stalled request lost");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |-> !(advance && result.has_result))
      else $error("response overwritten while stalled");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

   localparam int CLOCK_PERIOD   = 20;
   localparam int RESET_CYCLES   = 11;
   localparam int SETTLE_CYCLES  = 6;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 1950;
   localparam int RANDOM_PHASES  = 8;

   localparam logic [2:0] POS_TYPE    = 3'd0;
   localparam logic [2:0] POS_LEN_HI  = 3'd1;
   localparam logic [2:0] POS_LEN_MID = 3'd2;
   localparam logic [2:0] POS_LEN_LO  = 3'd3;
   localparam logic [2:0] POS_BODY    = 3'd4;

   localparam logic [23:0] LIMIT_ALL = 24'hFFFFFF;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [7:0] message_type;
      logic       is_header;
      logic       last_of_message;
      logic [1:0] status;
   } deframed_byte_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [23:0] csr_data;

   logic [23:0] body_limit;
   logic [2:0]  hdr_pos;
   logic [7:0]  held_type;
   logic [23:0] len_acc;
   logic [23:0] body_left;
   logic        err_latched;

   deframed_byte_type awaited_bytes[$];

   int mismatches    = 0;
   int requests_sent = 0;
   int clears_sent   = 0;
   int bytes_checked = 0;
   int length_errors = 0;
   int limit_writes  = 0;
   int idle_cycles   = 0;
   bit req_gaps_on   = 1'b1;
   bit rsp_stalls_on = 1'b1;

   tls_handshake_deframer_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   task automatic drop_message();
      hdr_pos     = POS_TYPE;
      held_type   = '0;
      len_acc     = '0;
      body_left   = '0;
      err_latched = 1'b0;
   endtask

   task automatic predict_deframe(input logic op, input logic [7:0] b);
      deframed_byte_type r;
      logic [23:0]       len;
      r   = '0;
      len = {len_acc[15:0], b};
      if (op == thd_pkg::OP_CLEAR) begin
         drop_message();
      end else begin
         if (err_latched) begin
            r.status = thd_pkg::STATUS_DROPPED;
         end else begin
            r.out_byte     = b;
            r.message_type = held_type;
            r.is_header    = 1'b1;
            r.status       = thd_pkg::STATUS_OK;
            case (hdr_pos)
               POS_TYPE: begin
                  held_type      = b;
                  r.message_type = b;
                  len_acc        = '0;
                  hdr_pos        = POS_LEN_HI;
               end
               POS_LEN_HI, POS_LEN_MID: begin
                  len_acc = len;
                  hdr_pos = hdr_pos + 3'd1;
               end
               POS_LEN_LO: begin
                  len_acc = len;
                  if (len > body_limit) begin
                     err_latched = 1'b1;
                     hdr_pos     = POS_TYPE;
                     r.status    = thd_pkg::STATUS_TOO_BIG;
                     length_errors++;
                  end else if (len == '0) begin
                     hdr_pos           = POS_TYPE;
                     r.last_of_message = 1'b1;
                  end else begin
                     body_left = len;
                     hdr_pos   = POS_BODY;
                  end
               end
               default: begin
                  r.is_header = 1'b0;
                  if (body_left != '0) body_left = body_left - 24'd1;
                  if (body_left == '0) begin
                     hdr_pos           = POS_TYPE;
                     r.last_of_message = 1'b1;
                  end
               end
            endcase
         end
         awaited_bytes.push_back(r);
      end
   endtask

   task automatic send_item(input logic op, input logic [7:0] b);
      int gap;
      @(negedge clock);
      if (req_gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      predict_deframe(op, b);
      requests_sent++;
      if (op == thd_pkg::OP_CLEAR) clears_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(thd_pkg::OP_BYTE, b);
   endtask

   task automatic send_clear();
      send_item(thd_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_message(input logic [7:0] kind, input logic [23:0] len,
                               input int body_count);
      send_byte(kind);
      send_byte(len[23:16]);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
      repeat (body_count) send_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic drain_rsp();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (awaited_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [23:0] value);
      drain_rsp();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      body_limit = value;
      limit_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_header_and_body();
      send_message(8'hFF, 24'd0, 0);
      send_message(8'h00, 24'd2, 0);
      send_byte(8'hFF);
      send_byte(8'h00);
   endtask

   task automatic test_length_errors_and_clear();
      send_message(8'h5A, LIMIT_ALL, 0);
      send_byte(8'hA5);
      send_clear();
      send_byte(8'h16);
      send_byte(8'h00);
      send_clear();
      send_message(8'h01, 24'd1, 1);
   endtask

   task automatic test_limit_settings();
      write_limit(LIMIT_ALL);
      send_message(8'h0B, LIMIT_ALL, 1);
      send_clear();
      write_limit(24'd2);
      send_byte(8'h0F);
      send_byte(8'h00);
      send_byte(8'h00);
      // tighten the limit before the last length byte arrives
      write_limit(24'd1);
      send_byte(8'h02);
      send_clear();
   endtask

   task automatic test_random_stream();
      int          start;
      int          phase_end;
      int          kind;
      int          cut;
      logic [23:0] limit;
      logic [23:0] len;
      logic [23:0] cap;
      start = requests_sent;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       limit = '0;
            1:       limit = LIMIT_ALL;
            3:       limit = 24'($urandom);
            default: limit = 24'($urandom_range(1, 20));
         endcase
         req_gaps_on   = (phase < RANDOM_PHASES - 2) && (phase != 2);
         rsp_stalls_on = (phase < RANDOM_PHASES - 2) && (phase != 3);
         write_limit(limit);
         phase_end = start + (phase + 1) * RANDOM_ITEMS / RANDOM_PHASES;
         cap = (body_limit < 24'd12) ? body_limit : 24'd12;
         while (requests_sent < phase_end) begin
            kind = $urandom_range(0, 19);
            if (kind == 0) begin
               send_clear();
            end else if (kind == 1) begin
               repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
               send_clear();
            end else if (kind == 2 && cap >= 24'd2) begin
               len = 24'($urandom_range(2, cap));
               cut = $urandom_range(1, len - 1);
               send_message(8'($urandom_range(0, 255)), len, cut);
               send_clear();
            end else if (kind == 3) begin
               repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
               send_clear();
            end else if (kind <= 5 && body_limit != LIMIT_ALL) begin
               if (body_limit < 24'hFFFFF0 && $urandom_range(0, 3) != 0)
                  len = body_limit + 24'($urandom_range(1, 15));
               else
                  len = LIMIT_ALL;
               send_message(8'($urandom_range(0, 255)), len, 0);
               repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
               send_clear();
            end else begin
               len = 24'($urandom_range(0, cap));
               send_message(8'($urandom_range(0, 255)), len, int'(len));
            end
         end
      end
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_stalls_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      deframed_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_bytes.size() == 0) begin
            report_mismatch($sformatf("response data %h user %h last %b with no request pending",
                                      rsp_tdata, rsp_tuser, rsp_tlast));
         end else begin
            want = awaited_bytes.pop_front();
            bytes_checked++;
            if (rsp_tdata[7:0] !== want.out_byte)
               report_mismatch($sformatf("out_byte %h, want %h", rsp_tdata[7:0], want.out_byte));
            if (rsp_tdata[15:8] !== want.message_type)
               report_mismatch($sformatf("message_type %h, want %h",
                                         rsp_tdata[15:8], want.message_type));
            if (rsp_tuser[0] !== want.is_header)
               report_mismatch($sformatf("is_header %b, want %b", rsp_tuser[0], want.is_header));
            if (rsp_tlast !== want.last_of_message)
               report_mismatch($sformatf("last_of_message %b, want %b",
                                         rsp_tlast, want.last_of_message));
            if (rsp_tuser[2:1] !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", rsp_tuser[2:1], want.status));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", idle_cycles);
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      body_limit = thd_pkg::MAX_BODY_LENGTH_RESET;
      drop_message();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_header_and_body();
      test_length_errors_and_clear();
      test_limit_settings();
      test_random_stream();
      drain_rsp();

      $display("Sent %0d requests (%0d clears) across %0d limit settings; %0d responses checked.",
               requests_sent, clears_sent, limit_writes, bytes_checked);
      $display("Length errors provoked: %0d; mismatches: %0d.", length_errors, mismatches);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/thd_pkg.sv
rtl/thd_core.sv
rtl/tls_handshake_deframer_unit.sv
tb/tb.sv
